>>> hdl/cmr_pkg.sv
// Package for the CAN message reassembler: payload structs, error codes, CRC step.
// No dependencies.
`timescale 1ns / 1ps
package cmr_pkg;

  typedef struct packed {
    logic [4:0]  seq_num;
    logic        ext_format;
    logic        single_flag;
    logic [11:0] msg_len;
    logic [7:0]  start_subtype;
    logic [17:0] crc_field;
    logic [6:0]  frm_bytes;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic        byte_stored;
    logic [9:0]  byte_index;
    logic [7:0]  data_out;
    logic [3:0]  fault_code;
    logic        restarted;
    logic        message_done;
    logic [10:0] message_length;
    logic [7:0]  message_subtype;
  } out_item_t;

  typedef enum logic [3:0] {
    ERR_NONE       = 4'd0,
    ERR_BAD_SEQ    = 4'd1,
    ERR_NOT_EXT    = 4'd2,
    ERR_TOO_LARGE  = 4'd3,
    ERR_EMPTY      = 4'd4,
    ERR_UNEXPECTED = 4'd5,
    ERR_TOO_SMALL  = 4'd6,
    ERR_CRC_FAIL   = 4'd7,
    ERR_ROLLOVER   = 4'd8
  } err_e;

  localparam logic [17:0] CRC_INIT = 18'h3FFFF;
  localparam logic [17:0] CRC_POLY = 18'h23979;

  // Message and frame limits
  localparam int unsigned MAX_MSG_LEN     = 1024;
  localparam int unsigned MAX_SEQ         = 31;
  localparam int unsigned MAX_FRAME_BYTES = 64;

  // Front-end classification of one item, queued to the back end.
  typedef struct packed {
    logic       first;
    logic [6:0] total;
    logic [7:0] data_byte;
    in_item_t   hdr;
  } cls_t;

  // One byte of MSB-first CRC-18 update.
  function automatic logic [17:0] crc_byte(input logic [17:0] crc, input logic [7:0] b);
    logic [17:0] r;
    r = {crc[17:10] ^ b, 10'd0};
    for (int i = 0; i < 8; i++) begin
      r = r[17] ? ({r[16:0], 1'b0} ^ CRC_POLY) : {r[16:0], 1'b0};
    end
    return {crc[9:0], 8'd0} ^ r;
  endfunction

endpackage

>>> hdl/cmr_front.sv
// Front end: accepts items, tracks frame boundaries, tags first items.
// Depends on cmr_pkg.
`timescale 1ns / 1ps
module cmr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cmr_pkg::in_item_t in_data_i,
  output logic              cls_valid_o,
  input  logic              cls_stall_i,
  output cmr_pkg::cls_t     cls_o
);
  import cmr_pkg::*;

  logic [6:0] pos_q, pos_d, tot_q;
  logic [6:0] tot_cur;
  logic       fire;

  assign in_stall_o  = cls_stall_i;
  assign cls_valid_o = in_valid_i;
  assign fire        = in_valid_i && !cls_stall_i;

  // Take the frame length from the first item only.
  always_comb begin
    tot_cur = (pos_q == 7'd0) ? ((in_data_i.frm_bytes == 7'd0) ? 7'd1 : in_data_i.frm_bytes)
                              : tot_q;
    pos_d   = (pos_q + 7'd1 >= tot_cur) ? 7'd0 : pos_q + 7'd1;
    cls_o.first     = (pos_q == 7'd0);
    cls_o.total     = tot_cur;
    cls_o.data_byte = in_data_i.data_byte;
    cls_o.hdr       = in_data_i;
  end

  // Advance frame position per transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      tot_q <= '0;
    end else if (fire) begin
      pos_q <= pos_d;
      tot_q <= tot_cur;
    end
  end
endmodule

>>> hdl/cmr_fifo.sv
// Two-entry queue between front and back end.
// Depends on cmr_pkg.
`timescale 1ns / 1ps
module cmr_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_stall_o,
  input  cmr_pkg::cls_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_stall_i,
  output cmr_pkg::cls_t rd_data_o
);
  import cmr_pkg::*;

  cls_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_stall_o = (cnt_q == 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && !wr_stall_o;
  assign rd = rd_valid_o && !rd_stall_i;

  // Store entries.
  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  // Move pointers and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

>>> hdl/cmr_back.sv
// Back end: header checks, byte storage, CRC and end-of-frame verdict.
// Depends on cmr_pkg.
`timescale 1ns / 1ps
module cmr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fd_mode_i,
  input  logic               cls_valid_i,
  output logic               cls_stall_o,
  input  cmr_pkg::cls_t      cls_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cmr_pkg::out_item_t out_data_o
);
  import cmr_pkg::*;

  logic [17:0] crc_q, crc_d, tgt_q, tgt_d;
  logic [10:0] asm_q, asm_d, exp_q, exp_d;
  logic [4:0]  nseq_q, nseq_d;
  logic [7:0]  sub_q, sub_d;
  logic [6:0]  keep_q, keep_d, pos_q, pos_d;
  logic        last_q, last_d, sgl_q, sgl_d, drop_q, drop_d;
  logic        ov_q;
  out_item_t   res_q, res;
  logic        take;

  assign cls_stall_o = ov_q && out_stall_i;
  assign take        = cls_valid_i && !cls_stall_o;
  assign out_valid_o = ov_q;
  assign out_data_o  = res_q;

  // Judge one item.
  always_comb begin
    logic [3:0]  err;
    logic [6:0]  keep, flen;
    logic        last, single, emit;
    logic [12:0] sum;
    in_item_t    h;
    h = cls_i.hdr;
    crc_d = crc_q; tgt_d = tgt_q; asm_d = asm_q; exp_d = exp_q; nseq_d = nseq_q;
    sub_d = sub_q; keep_d = keep_q; pos_d = pos_q;
    last_d = last_q; sgl_d = sgl_q; drop_d = drop_q;
    res = '0; err = ERR_NONE; emit = 1'b1;
    flen = h.frm_bytes; keep = flen; last = 1'b0; single = 1'b0;
    sum = '0;
    if (cls_i.first) begin
      if (h.seq_num == 5'd0) begin
        if (nseq_q != 5'd0) begin
          res.restarted = 1'b1;
          crc_d = CRC_INIT; asm_d = '0; nseq_d = '0;
        end
        if (!h.ext_format) err = ERR_NOT_EXT;
        else if ({1'b0, h.msg_len} > 13'(MAX_MSG_LEN) || h.msg_len == 12'd0)
          err = ERR_TOO_LARGE;
        else begin
          sub_d = h.start_subtype; exp_d = h.msg_len[10:0];
          last = h.single_flag; single = h.single_flag;
        end
      end else begin
        last = h.ext_format;
        tgt_d = h.crc_field;
        if (h.seq_num != nseq_q) err = ERR_BAD_SEQ;
      end
      sum = 13'(flen) + 13'(asm_d);
      if (err == ERR_NONE) begin
        if (flen == 7'd0) err = ERR_EMPTY;
        else if (8'(flen) > 8'(MAX_FRAME_BYTES)) err = ERR_UNEXPECTED;
        else if (sum > 13'(exp_d)) begin
          if (!last || !fd_mode_i) err = ERR_UNEXPECTED;
          else keep = (exp_d > asm_d) ? 7'(exp_d - asm_d) : 7'd0;
        end
      end
      if (err != ERR_NONE) begin
        crc_d = CRC_INIT; asm_d = '0; nseq_d = '0;
        res.fault_code = err;
        emit = 1'b0;
        if (cls_i.total > 7'd1) begin
          drop_d = 1'b1; last_d = 1'b0; sgl_d = 1'b0; pos_d = 7'd1;
        end
      end else begin
        last_d = last; sgl_d = single; drop_d = 1'b0; keep_d = keep; pos_d = '0;
      end
    end else if (drop_q) begin
      emit = 1'b0;
      pos_d = pos_q + 7'd1;
      if (pos_d >= cls_i.total) begin
        pos_d = '0; drop_d = 1'b0;
      end
    end
    if (emit) begin
      if (pos_d < keep_d) begin
        res.byte_stored = 1'b1;
        res.byte_index  = asm_d[9:0];
        res.data_out    = cls_i.data_byte;
        if (!sgl_d) crc_d = crc_byte(crc_d, cls_i.data_byte);
        asm_d = asm_d + 11'd1;
      end
      pos_d = pos_d + 7'd1;
      if (pos_d >= cls_i.total) begin
        pos_d = '0;
        last_d = 1'b0; sgl_d = 1'b0; drop_d = 1'b0;
        if (last_q | (cls_i.first & last)) begin
          if (asm_d < exp_d) err = ERR_TOO_SMALL;
          else if (!(cls_i.first ? single : sgl_q) && crc_d != tgt_d) err = ERR_CRC_FAIL;
          if (err == ERR_NONE) begin
            res.message_done    = 1'b1;
            res.message_length  = asm_d;
            res.message_subtype = sub_d;
          end
          crc_d = CRC_INIT; asm_d = '0; nseq_d = '0;
        end else if (asm_d >= exp_d) begin
          err = ERR_TOO_LARGE;
          crc_d = CRC_INIT; asm_d = '0; nseq_d = '0;
        end else if (32'(nseq_d) >= MAX_SEQ) begin
          if (fd_mode_i) begin
            err = ERR_ROLLOVER;
            crc_d = CRC_INIT; asm_d = '0; nseq_d = '0;
          end else nseq_d = 5'd1;
        end else nseq_d = nseq_d + 5'd1;
        res.fault_code = err;
      end
    end
  end

  // Commit state and hold the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CRC_INIT; tgt_q <= '0; asm_q <= '0; exp_q <= '0; nseq_q <= '0;
      sub_q <= '0; keep_q <= '0; pos_q <= '0;
      last_q <= 1'b0; sgl_q <= 1'b0; drop_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      if (take) begin
        crc_q <= crc_d; tgt_q <= tgt_d; asm_q <= asm_d; exp_q <= exp_d;
        nseq_q <= nseq_d; sub_q <= sub_d; keep_q <= keep_d; pos_q <= pos_d;
        last_q <= last_d; sgl_q <= sgl_d; drop_q <= drop_d;
        ov_q <= 1'b1;
      end else if (!out_stall_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) res_q <= res;
  end
endmodule

>>> hdl/can_message_reassembler_crc18_unit.sv
// Top level of the CAN message reassembler with CRC-18 check.
// Depends on cmr_pkg, cmr_front, cmr_fifo, cmr_back.
`timescale 1ns / 1ps
// Takes one payload byte per transfer with its frame's unpacked identifier
// fields and returns one result per item, one item per cycle sustained while
// the output does not stall; a result passes through the two-entry queue
// between the frame tracker and the checking stage and then the output
// register. Output stalls hold the checking stage and, once the queue fills,
// the input. The user must write fd_mode through its own valid/ready port
// only while the block is idle; the block itself does not enforce this.
module can_message_reassembler_crc18_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cmr_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cmr_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i
);
  import cmr_pkg::*;

  logic fd_q;
  logic f_valid, f_stall, b_valid, b_stall;
  cls_t f_data, b_data;

  assign cfg_ready_o = 1'b1;

  // Hold the mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fd_q <= 1'b0;
    else if (cfg_valid_i && cfg_ready_o) fd_q <= cfg_data_i;
  end

  cmr_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .cls_valid_o(f_valid), .cls_stall_i(f_stall), .cls_o(f_data)
  );

  cmr_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_stall_o(f_stall), .wr_data_i(f_data),
    .rd_valid_o(b_valid), .rd_stall_i(b_stall), .rd_data_o(b_data)
  );

  cmr_back u_back (
    .clk_i, .rst_ni, .fd_mode_i(fd_q),
    .cls_valid_i(b_valid), .cls_stall_o(b_stall), .cls_i(b_data),
    .out_valid_o, .out_stall_i, .out_data_o
  );
endmodule
